### rtl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// shared types and constants for the sync/length/checksum deframer
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QAW     = $clog2(QDEPTH);
    localparam int unsigned QCW     = $clog2(QDEPTH + 1);
    localparam int unsigned TDATA_W = 40;

    // sync sequence
    localparam logic [BYTE_W-1:0] SYNC_B0 = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_B1 = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_B2 = 8'h03;

    // one result word as it travels from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] frame_subtype;
        logic [BYTE_W-1:0] payload_len;
        logic              frame_end;
        logic              checksum_ok;
    } t_item;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### rtl/slcd_front.sv
// ----------------------------------------------------------------------------
// slcd_front
// frame parser: sync hunt, header capture, running sum, result generation
// ----------------------------------------------------------------------------
module slcd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [slcd_pkg::BYTE_W-1:0]  i_rx_byte,
    input  slcd_pkg::t_q_stat            i_q_stat,
    output logic                         o_push,
    output slcd_pkg::t_item              o_item
);
    import slcd_pkg::*;

    localparam logic [2:0] PH_SYNC0   = 3'd0;
    localparam logic [2:0] PH_SYNC1   = 3'd1;
    localparam logic [2:0] PH_SYNC2   = 3'd2;
    localparam logic [2:0] PH_TYPE    = 3'd3;
    localparam logic [2:0] PH_SUBTYPE = 3'd4;
    localparam logic [2:0] PH_LENGTH  = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;
    localparam logic [2:0] PH_CHECK   = 3'd7;

    logic [2:0]        r_phase,   n_phase;
    logic [BYTE_W-1:0] r_sum,     n_sum;
    logic [BYTE_W-1:0] r_count,   n_count;
    logic [BYTE_W-1:0] r_len,     n_len;
    logic [BYTE_W-1:0] r_type,    n_type;
    logic [BYTE_W-1:0] r_subtype, n_subtype;
    logic              w_accept;
    logic              w_emit;
    logic [BYTE_W-1:0] w_sum_add;
    logic [BYTE_W-1:0] w_count_inc;

    assign o_ready     = ~i_q_stat.full;
    assign w_accept    = i_valid & o_ready;
    assign w_sum_add   = r_sum + i_rx_byte;
    assign w_count_inc = r_count + 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_sum     = r_sum;
        n_count   = r_count;
        n_len     = r_len;
        n_type    = r_type;
        n_subtype = r_subtype;
        w_emit    = 1'b0;
        o_item.data_byte     = i_rx_byte;
        o_item.byte_index    = r_count;
        o_item.frame_type    = r_type;
        o_item.frame_subtype = r_subtype;
        o_item.payload_len   = r_len;
        o_item.frame_end     = 1'b0;
        o_item.checksum_ok   = 1'b0;
        case (r_phase)
            PH_SYNC0: begin
                if (i_rx_byte == SYNC_B0) begin
                    n_sum   = i_rx_byte;
                    n_count = '0;
                    n_phase = PH_SYNC1;
                end
            end
            PH_SYNC1, PH_SYNC2: begin
                if ((r_phase == PH_SYNC1 && i_rx_byte == SYNC_B1) ||
                    (r_phase == PH_SYNC2 && i_rx_byte == SYNC_B2)) begin
                    n_sum   = w_sum_add;
                    n_phase = r_phase + 3'd1;
                end else begin
                    // wrong sync byte: drop and hunt again
                    n_sum   = '0;
                    n_count = '0;
                    n_phase = PH_SYNC0;
                end
            end
            PH_TYPE: begin
                n_type  = i_rx_byte;
                n_sum   = w_sum_add;
                n_phase = PH_SUBTYPE;
            end
            PH_SUBTYPE: begin
                n_subtype = i_rx_byte;
                n_sum     = w_sum_add;
                n_phase   = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_len   = i_rx_byte;
                n_sum   = w_sum_add;
                n_count = '0;
                n_phase = (i_rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                w_emit = 1'b1;
                n_sum  = w_sum_add;
                if (w_count_inc == r_len || r_len == '0) begin
                    n_phase = PH_CHECK;
                end else begin
                    n_count = w_count_inc;
                end
            end
            PH_CHECK: begin
                w_emit               = 1'b1;
                o_item.byte_index    = '0;
                o_item.frame_end     = 1'b1;
                o_item.checksum_ok   = (i_rx_byte == r_sum);
                n_sum                = '0;
                n_count              = '0;
                n_phase              = PH_SYNC0;
            end
            default: begin
                n_phase = PH_SYNC0;
            end
        endcase
    end

    assign o_push = w_accept & w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SYNC0;
            r_sum     <= '0;
            r_count   <= '0;
            r_len     <= '0;
            r_type    <= '0;
            r_subtype <= '0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_sum     <= n_sum;
            r_count   <= n_count;
            r_len     <= n_len;
            r_type    <= n_type;
            r_subtype <= n_subtype;
        end
    end

endmodule

### rtl/slcd_queue.sv
// ----------------------------------------------------------------------------
// slcd_queue
// short result queue between parser and output stage
// ----------------------------------------------------------------------------
module slcd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  slcd_pkg::t_item   i_item,
    input  logic              i_pop,
    output slcd_pkg::t_item   o_item,
    output slcd_pkg::t_q_stat o_stat
);
    import slcd_pkg::*;

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;

    assign o_stat.full  = (r_count == QCW'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_item       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

endmodule

### rtl/slcd_back.sv
// ----------------------------------------------------------------------------
// slcd_back
// output register stage: drains the queue and formats the stream word
// ----------------------------------------------------------------------------
module slcd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slcd_pkg::t_q_stat             i_q_stat,
    input  slcd_pkg::t_item               i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [slcd_pkg::TDATA_W-1:0]  o_data,
    output logic                          o_last,
    output logic                          o_user
);
    import slcd_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_pop = ~i_q_stat.empty & (~r_valid | i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {r_item.payload_len, r_item.frame_subtype, r_item.frame_type,
                      r_item.byte_index, r_item.data_byte};
    assign o_last  = r_item.frame_end;
    assign o_user  = r_item.checksum_ok;

endmodule

### rtl/sync_length_checksum_deframer_unit.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_unit
// a word that makes a result is written into the result queue, then into the output register that drives m_axis
// throughput: one word per cycle, sustained while m_axis_tready stays high
// the parser takes a word whenever the four-entry result queue has room
// reset: synchronous active-low i_rst_n; parser hunts for sync, sums/header cleared
// queue pointers and output valid cleared; payload registers keep old data
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // received byte stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
    // deframed result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] data_byte, [15:8] byte_index, [23:16] frame_type,
    // [31:24] frame_subtype, [39:32] payload_len
    output logic [slcd_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast,   // frame_end
    output logic                          m_axis_tuser    // [0] checksum_ok
);
    import slcd_pkg::*;

    // front to queue
    logic    w_push;
    t_item   w_push_item;
    // queue to back
    logic    w_pop;
    t_item   w_head_item;
    t_q_stat w_q_stat;

    // parser: sync hunt, header capture, running sum
    slcd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_rx_byte (s_axis_tdata),
        .i_q_stat  (w_q_stat),
        .o_push    (w_push),
        .o_item    (w_push_item)
    );

    // decouples parser from downstream stalls
    slcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_stat  (w_q_stat)
    );

    // output register; pops the queue whenever the queue holds a word and the register is empty or being drained
    slcd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_item   (w_head_item),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast),
        .o_user   (m_axis_tuser)
    );

    // queue never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("result queue overflow");

    // never popped while empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("result queue underflow");

    // verdict words carry index zero
    a_end_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[15:8] == 8'd0))
        else $error("frame end word with nonzero index");

    // payload words never claim a good checksum
    a_payload_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !m_axis_tuser)
        else $error("payload word with checksum flag set");

endmodule

### test/sync_length_checksum_deframer_unit_checker.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_unit_checker
// watches both streams, predicts the deframed words from the received bytes
// and compares every outgoing word with the oldest prediction
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_unit_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [7:0]                   i_in_data,    // [7:0] rx_byte
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    // [7:0] data_byte, [15:8] byte_index, [23:16] frame_type,
    // [31:24] frame_subtype, [39:32] payload_len
    input  logic [slcd_pkg::TDATA_W-1:0] i_out_data,
    input  logic                         i_out_last,   // frame_end
    input  logic                         i_out_user,   // [0] checksum_ok
    output int                           o_fail_count,
    output int                           o_pending
);
    import slcd_pkg::*;

    typedef enum logic [2:0] {
        HUNT_55,
        WANT_AA,
        WANT_03,
        TAKE_TYPE,
        TAKE_SUBTYPE,
        TAKE_LEN,
        TAKE_PAYLOAD,
        TAKE_CHECKSUM
    } t_parse_phase;

    t_parse_phase parse_phase;
    logic [7:0]   frame_sum;
    logic [7:0]   payload_pos;
    logic [7:0]   frame_len;
    logic [7:0]   frame_kind;
    logic [7:0]   frame_subkind;
    t_item        words_due[$];

    task automatic report_mismatch(input string what);
        $display("deframer mismatch at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function automatic void restart_hunt();
        parse_phase = HUNT_55;
        frame_sum   = '0;
        payload_pos = '0;
    endfunction

    // advance the frame parser by one byte, returns 1 when a word comes out
    function automatic bit deframe_byte(input logic [7:0] b, output t_item word);
        bit made;
        made = 1'b0;
        word = '0;
        word.frame_type    = frame_kind;
        word.frame_subtype = frame_subkind;
        word.payload_len   = frame_len;
        case (parse_phase)
            HUNT_55: begin
                if (b == SYNC_B0) begin
                    frame_sum   = b;
                    payload_pos = '0;
                    parse_phase = WANT_AA;
                end
            end
            WANT_AA: begin
                if (b == SYNC_B1) begin
                    frame_sum   = frame_sum + b;
                    parse_phase = WANT_03;
                end else begin
                    restart_hunt();
                end
            end
            WANT_03: begin
                if (b == SYNC_B2) begin
                    frame_sum   = frame_sum + b;
                    parse_phase = TAKE_TYPE;
                end else begin
                    restart_hunt();
                end
            end
            TAKE_TYPE: begin
                frame_kind  = b;
                frame_sum   = frame_sum + b;
                parse_phase = TAKE_SUBTYPE;
            end
            TAKE_SUBTYPE: begin
                frame_subkind = b;
                frame_sum     = frame_sum + b;
                parse_phase   = TAKE_LEN;
            end
            TAKE_LEN: begin
                frame_len   = b;
                frame_sum   = frame_sum + b;
                payload_pos = '0;
                parse_phase = (b == 8'd0) ? TAKE_CHECKSUM : TAKE_PAYLOAD;
            end
            TAKE_PAYLOAD: begin
                word.data_byte  = b;
                word.byte_index = payload_pos;
                frame_sum       = frame_sum + b;
                made            = 1'b1;
                if (payload_pos + 8'd1 == frame_len)
                    parse_phase = TAKE_CHECKSUM;
                else
                    payload_pos = payload_pos + 8'd1;
            end
            default: begin
                // verdict word, sum covers sync, header and payload but not this byte
                word.data_byte   = b;
                word.frame_end   = 1'b1;
                word.checksum_ok = (b == frame_sum);
                made             = 1'b1;
                restart_hunt();
            end
        endcase
        return made;
    endfunction

    always @(posedge i_clk) begin
        t_item predicted;
        t_item oldest;
        t_item seen;
        if (!i_rst_n) begin
            restart_hunt();
            frame_len     = '0;
            frame_kind    = '0;
            frame_subkind = '0;
            words_due.delete();
            o_pending     = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (deframe_byte(i_in_data, predicted))
                    words_due.insert(words_due.size(), predicted);
            end
            if (i_out_valid && i_out_ready) begin
                seen.data_byte     = i_out_data[7:0];
                seen.byte_index    = i_out_data[15:8];
                seen.frame_type    = i_out_data[23:16];
                seen.frame_subtype = i_out_data[31:24];
                seen.payload_len   = i_out_data[39:32];
                seen.frame_end     = i_out_last;
                seen.checksum_ok   = i_out_user;
                if (words_due.size() == 0) begin
                    report_mismatch("result word with nothing pending");
                end else begin
                    oldest = words_due.pop_front();
                    compare_field("data_byte", seen.data_byte, oldest.data_byte);
                    compare_field("byte_index", seen.byte_index, oldest.byte_index);
                    compare_field("frame_type", seen.frame_type, oldest.frame_type);
                    compare_field("frame_subtype", seen.frame_subtype,
                                  oldest.frame_subtype);
                    compare_field("payload_len", seen.payload_len, oldest.payload_len);
                    compare_field("frame_end", {7'd0, seen.frame_end},
                                  {7'd0, oldest.frame_end});
                    compare_field("checksum_ok", {7'd0, seen.checksum_ok},
                                  {7'd0, oldest.checksum_ok});
                end
            end
            o_pending = words_due.size();
        end
    end

endmodule

### test/sync_length_checksum_deframer_unit_test.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_unit_test
// drives framed and broken byte streams into the deframer with random gaps
// on both sides; the checker beside the block predicts and compares words
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_unit_test;
    import slcd_pkg::*;

    // cycles with no word moving on either side before the run is called hung
    localparam int QUIET_LIMIT = 1000;
    // frame bytes to send in the random part
    localparam int FRAME_WORDS = 550;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = 8'd0;   // [7:0] rx_byte
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [7:0] data_byte, [15:8] byte_index, [23:16] frame_type,
    // [31:24] frame_subtype, [39:32] payload_len
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;           // frame_end
    logic               m_axis_tuser;           // [0] checksum_ok

    int fail_count;
    int words_pending;
    int frame_words_sent;
    int quiet_cycles;
    bit sender_calm;
    bit receiver_calm;
    int receiver_stall_left;
    int receiver_mode_left;

    sync_length_checksum_deframer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    sync_length_checksum_deframer_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // receiver side: random stalls, with calm stretches where it never stalls
    always @(negedge i_clk) begin
        if (receiver_mode_left == 0) begin
            receiver_calm      = ($urandom_range(0, 3) == 0);
            receiver_mode_left = $urandom_range(50, 300);
        end else begin
            receiver_mode_left--;
        end
        if (receiver_stall_left > 0) begin
            receiver_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!receiver_calm && $urandom_range(0, 3) == 0) begin
            receiver_stall_left = pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // hang detection: count cycles with no word accepted on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("sync_length_checksum_deframer_unit_test: errors");
                    $finish;
                end
            end
        end
    end

    // one byte across the input handshake; starts and ends at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (!sender_calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // sender holds off until every predicted word has come out
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (words_pending != 0);
    endtask

    // full frame: sync, type, subtype, length, random payload, checksum
    task automatic send_frame(input logic [7:0] kind, input logic [7:0] subkind,
                              input logic [7:0] len, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = SYNC_B0 + SYNC_B1 + SYNC_B2 + kind + subkind + len;
        send_byte(SYNC_B0);
        send_byte(SYNC_B1);
        send_byte(SYNC_B2);
        send_byte(kind);
        send_byte(subkind);
        send_byte(len);
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom_range(0, 255));
            sum = sum + b;
            send_byte(b);
        end
        // a bad checksum is off by a nonzero amount
        send_byte(corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
        frame_words_sent += int'(len) + 7;
    endtask

    initial begin
        int r;
        int n;
        logic [7:0] b;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme bytes while hunting
        send_byte(8'h00);
        send_byte(8'hFF);
        // wrong second sync byte, a repeated 0x55 does not restart the sync
        send_byte(SYNC_B0);
        send_byte(SYNC_B0);
        send_byte(SYNC_B1);
        send_byte(SYNC_B2);
        // wrong third sync byte
        send_byte(SYNC_B0);
        send_byte(SYNC_B1);
        send_byte(8'h00);
        // zero-length frame, checksum follows the length byte directly
        send_frame(8'hFF, 8'h00, 8'd0, 1'b0);
        // one payload byte with a bad checksum
        send_frame(8'h00, 8'hFF, 8'd1, 1'b1);

        hold_until_drained();

        // random: mostly well-formed frames, some noise and broken syncs
        frame_words_sent = 0;
        while (frame_words_sent < FRAME_WORDS) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 78) begin
                n = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 12);
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'(n), $urandom_range(0, 5) == 0);
            end else if (r < 89) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    b = 8'($urandom_range(0, 255));
                    send_byte(b);
                end
            end else begin
                // sync cut short by a random byte
                send_byte(SYNC_B0);
                if ($urandom_range(0, 1) == 1)
                    send_byte(SYNC_B1);
                b = 8'($urandom_range(0, 255));
                send_byte(b);
            end
            if ($urandom_range(0, 14) == 0)
                hold_until_drained();
        end

        s_axis_tvalid <= 1'b0;
        while (words_pending != 0) @(negedge i_clk);
        // keep watching the output to catch stray words
        repeat (8) @(negedge i_clk);
        if (fail_count == 0)
            $display("sync_length_checksum_deframer_unit_test: clean");
        else
            $display("sync_length_checksum_deframer_unit_test: errors");
        $finish;
    end

endmodule
